// ===== hdl/c3f_pkg.sv =====
// ----------------------------------------------------------------------------
// c3f_pkg
// Shared constants, types and helpers of the 3x3 image filter.
// ----------------------------------------------------------------------------
package c3f_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;

    localparam int PIX_W       = 8;
    localparam int COEF_W      = 4;
    localparam int NUM_TAPS    = 9;
    localparam int KERN_W      = NUM_TAPS * COEF_W;
    localparam int DIM_W       = 11;
    localparam int POS_W       = 10;
    localparam int PROD_W      = 13;
    localparam int VAL_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = KERN_W;

    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    // per-pixel control carried down the pipeline
    typedef struct packed {
        logic             e_win;
        logic             inner;
        logic             e_end;
        logic             e_last;
        logic             img_end;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] px;
    } t_stage;

    // one queued request: up to three results of one pixel
    typedef struct packed {
        logic                    e_win;
        logic                    e_end;
        logic                    e_last;
        logic                    img_end;
        logic signed [VAL_W-1:0] win_val;
        logic [PIX_W-1:0]        end_val;
        logic [PIX_W-1:0]        last_val;
        logic [POS_W-1:0]        row;
        logic [POS_W-1:0]        col;
    } t_rec;

    function automatic logic [DIM_W-1:0] clamp_dim(
        input logic [DIM_W-1:0] v,
        input logic [DIM_W-1:0] hi
    );
        logic [DIM_W-1:0] res;
        if (v < DIM_W'(3)) begin
            res = DIM_W'(3);
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

// ===== hdl/conv3x3_image_filter_top.sv =====
// ----------------------------------------------------------------------------
// conv3x3_image_filter_top
// 3x3 convolution over a raster-order 8-bit pixel stream, borders passed through.
// ----------------------------------------------------------------------------
// Usage:
//   pixel channel: i_in_valid / o_in_stall with i_pixel, one pixel per request
//   in raster order. Result channel: o_out_valid / i_out_stall with o_value,
//   o_out_row, o_out_col, o_last_of_run and o_last_of_image.
//   Configuration: i_cfg_we / i_cfg_index / i_cfg_data, written while idle.
//   Throughput: one pixel per cycle while o_in_stall is low. Each pixel gives zero to three results;
//   row ends and the last row give more, and the eight-entry request queue
//   absorbs them, raising o_in_stall when queue plus the three in-flight
//   pipeline stages could overflow.
//   Path: a taken pixel passes the line store read, window shift, tap multiply,
//   tap sum and queue, in that order, before its first result is shown.
//   Reset: counters, window and queue clear, kernel is zero, geometry is
//   1024 x 1024; the line stores are not cleared and need no clearing pass.
//   A stalled result holds; a full queue stalls the pixel side, and requests
//   already in the pipeline always find room.
// ----------------------------------------------------------------------------
module conv3x3_image_filter_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [c3f_pkg::PIX_W-1:0]             i_pixel,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [c3f_pkg::VAL_W-1:0]      o_value,
    output logic [c3f_pkg::POS_W-1:0]             o_out_row,
    output logic [c3f_pkg::POS_W-1:0]             o_out_col,
    output logic                                  o_last_of_run,
    output logic                                  o_last_of_image,
    input  logic                                  i_cfg_we,
    input  logic [c3f_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [c3f_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    logic [c3f_pkg::KERN_W-1:0]  r_kernel;
    logic [c3f_pkg::DIM_W-1:0]   r_width;
    logic [c3f_pkg::DIM_W-1:0]   r_height;
    logic [c3f_pkg::POS_W-1:0]   r_row;
    logic [c3f_pkg::POS_W-1:0]   r_col;

    logic                        r_s1v;
    logic                        r_s2v;
    logic                        r_s3v;
    c3f_pkg::t_stage             r_s1;
    c3f_pkg::t_stage             r_s2;
    c3f_pkg::t_stage             r_s3;
    logic [c3f_pkg::PIX_W-1:0]   r_ctr;
    logic [c3f_pkg::PIX_W-1:0]   r_rgt;

    logic                        w_accept;
    logic [c3f_pkg::DIM_W-1:0]   w_wm1;
    logic [c3f_pkg::DIM_W-1:0]   w_hm1;
    logic [c3f_pkg::DIM_W-1:0]   w_col_ext;
    logic [c3f_pkg::DIM_W-1:0]   w_row_ext;
    logic                        w_row_end;
    logic                        w_last_row;
    c3f_pkg::t_stage             n_s1;

    logic [c3f_pkg::PIX_W-1:0]   w_up;
    logic [c3f_pkg::PIX_W-1:0]   w_mid;
    logic [c3f_pkg::PIX_W-1:0]   w_pix  [3][3];
    logic signed [c3f_pkg::PROD_W-1:0] w_prod [c3f_pkg::NUM_TAPS];
    logic [c3f_pkg::PIX_W-1:0]   w_feed [3];

    logic signed [c3f_pkg::VAL_W-1:0]  w_sum;
    c3f_pkg::t_rec               w_rec;
    logic                        w_push;
    logic [c3f_pkg::QCNT_W-1:0]  w_count;
    logic [c3f_pkg::QCNT_W:0]    w_need;

    // flow control
    always_comb begin
        w_need = (c3f_pkg::QCNT_W + 1)'(w_count) + (c3f_pkg::QCNT_W + 1)'(r_s1v)
               + (c3f_pkg::QCNT_W + 1)'(r_s2v) + (c3f_pkg::QCNT_W + 1)'(r_s3v);
        o_in_stall = !i_rst_n || (w_need >= (c3f_pkg::QCNT_W + 1)'(c3f_pkg::QUEUE_DEPTH));
        w_accept   = i_in_valid && !o_in_stall;
    end

    // position decode
    always_comb begin
        w_wm1 = c3f_pkg::clamp_dim(r_width, c3f_pkg::DIM_W'(c3f_pkg::MAX_WIDTH))
              - c3f_pkg::DIM_W'(1);
        w_hm1 = c3f_pkg::clamp_dim(r_height, c3f_pkg::DIM_W'(c3f_pkg::MAX_HEIGHT))
              - c3f_pkg::DIM_W'(1);
        w_col_ext  = {1'b0, r_col};
        w_row_ext  = {1'b0, r_row};
        w_row_end  = (w_col_ext >= w_wm1);
        w_last_row = (w_row_ext >= w_hm1);
        n_s1.e_win   = (r_row != '0) && (r_col != '0);
        n_s1.inner   = (r_row >= c3f_pkg::POS_W'(2)) && (r_col >= c3f_pkg::POS_W'(2))
                    && (w_row_ext <= w_hm1) && (w_col_ext <= w_wm1);
        n_s1.e_end   = w_row_end && (r_row != '0);
        n_s1.e_last  = w_last_row;
        n_s1.img_end = w_row_end && w_last_row;
        n_s1.row     = r_row;
        n_s1.col     = r_col;
        n_s1.px      = i_pixel;
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel <= '0;
            r_width  <= c3f_pkg::DIM_W'(c3f_pkg::MAX_WIDTH);
            r_height <= c3f_pkg::DIM_W'(c3f_pkg::MAX_HEIGHT);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                c3f_pkg::REG_KERNEL: r_kernel <= i_cfg_data[c3f_pkg::KERN_W-1:0];
                c3f_pkg::REG_WIDTH:  r_width  <= i_cfg_data[c3f_pkg::DIM_W-1:0];
                c3f_pkg::REG_HEIGHT: r_height <= i_cfg_data[c3f_pkg::DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // raster counters and pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_s1v <= 1'b0;
            r_s2v <= 1'b0;
            r_s3v <= 1'b0;
        end else begin
            if (w_accept) begin
                if (w_row_end) begin
                    r_col <= '0;
                    r_row <= w_last_row ? '0 : r_row + c3f_pkg::POS_W'(1);
                end else begin
                    r_col <= r_col + c3f_pkg::POS_W'(1);
                end
            end
            r_s1v <= w_accept;
            r_s2v <= r_s1v;
            r_s3v <= r_s2v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= n_s1;
        end
        if (r_s1v) begin
            r_s2 <= r_s1;
        end
        if (r_s2v) begin
            r_s3  <= r_s2;
            r_ctr <= w_pix[1][1];
            r_rgt <= w_pix[1][2];
        end
    end

    c3f_line_buf u_line_buf (
        .i_clk       (i_clk),
        .i_rd_en     (w_accept),
        .i_rd_addr   (r_col),
        .i_mid_wdata (i_pixel),
        .i_up_we     (r_s1v),
        .i_up_waddr  (r_s1.col),
        .o_up        (w_up),
        .o_mid       (w_mid)
    );

    assign w_feed[0] = w_up;
    assign w_feed[1] = w_mid;
    assign w_feed[2] = r_s1.px;

    // window: three rows of taps, newest column on the right
    for (genvar gi = 0; gi < 3; gi++) begin : g_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_col
            logic [c3f_pkg::PIX_W-1:0] w_in;
            if (gj == 2) begin : g_feed
                assign w_in = w_feed[gi];
            end else begin : g_chain
                assign w_in = w_pix[gi][gj+1];
            end
            c3f_tap_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_shift  (r_s1v),
                .i_pix    (w_in),
                .i_coeff  ($signed(r_kernel[c3f_pkg::COEF_W*(gi*3+gj) +: c3f_pkg::COEF_W])),
                .i_mul_en (r_s2v),
                .o_pix    (w_pix[gi][gj]),
                .o_prod   (w_prod[gi*3+gj])
            );
        end
    end

    // tap sum and queue request
    always_comb begin
        w_sum = '0;
        for (int k = 0; k < c3f_pkg::NUM_TAPS; k++) begin
            w_sum = w_sum + c3f_pkg::VAL_W'(w_prod[k]);
        end
        w_rec.e_win    = r_s3.e_win;
        w_rec.e_end    = r_s3.e_end;
        w_rec.e_last   = r_s3.e_last;
        w_rec.img_end  = r_s3.img_end;
        w_rec.win_val  = r_s3.inner ? w_sum
                       : $signed({{(c3f_pkg::VAL_W - c3f_pkg::PIX_W){1'b0}}, r_ctr});
        w_rec.end_val  = r_rgt;
        w_rec.last_val = r_s3.px;
        w_rec.row      = r_s3.row;
        w_rec.col      = r_s3.col;
        w_push = r_s3v && (r_s3.e_win || r_s3.e_end || r_s3.e_last);
    end

    c3f_out_queue u_out_queue (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (w_push),
        .i_rec           (w_rec),
        .o_count         (w_count),
        .o_valid         (o_out_valid),
        .i_stall         (i_out_stall),
        .o_value         (o_value),
        .o_row           (o_out_row),
        .o_col           (o_out_col),
        .o_last_of_run   (o_last_of_run),
        .o_last_of_image (o_last_of_image)
    );

endmodule

// ===== hdl/c3f_tap_cell.sv =====
// ----------------------------------------------------------------------------
// c3f_tap_cell
// One window tap: holds a pixel, passes it on, registers pixel times coefficient.
// ----------------------------------------------------------------------------
module c3f_tap_cell (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_shift,
    input  logic [c3f_pkg::PIX_W-1:0]            i_pix,
    input  logic signed [c3f_pkg::COEF_W-1:0]    i_coeff,
    input  logic                                 i_mul_en,
    output logic [c3f_pkg::PIX_W-1:0]            o_pix,
    output logic signed [c3f_pkg::PROD_W-1:0]    o_prod
);

    logic [c3f_pkg::PIX_W-1:0]         r_pix;
    logic signed [c3f_pkg::PROD_W-1:0] r_prod;
    logic signed [c3f_pkg::PROD_W-1:0] n_prod;
    logic signed [c3f_pkg::PROD_W-1:0] w_a;
    logic signed [c3f_pkg::PROD_W-1:0] w_b;

    always_comb begin
        w_a    = $signed({{(c3f_pkg::PROD_W - c3f_pkg::PIX_W){1'b0}}, r_pix});
        w_b    = {{(c3f_pkg::PROD_W - c3f_pkg::COEF_W){i_coeff[c3f_pkg::COEF_W-1]}}, i_coeff};
        n_prod = w_a * w_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix <= '0;
        end else if (i_shift) begin
            r_pix <= i_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_pix  = r_pix;
    assign o_prod = r_prod;

endmodule

// ===== hdl/c3f_line_buf.sv =====
// ----------------------------------------------------------------------------
// c3f_line_buf
// Upper and middle line stores with registered read data.
// ----------------------------------------------------------------------------
module c3f_line_buf (
    input  logic                         i_clk,
    input  logic                         i_rd_en,
    input  logic [c3f_pkg::POS_W-1:0]    i_rd_addr,
    input  logic [c3f_pkg::PIX_W-1:0]    i_mid_wdata,
    input  logic                         i_up_we,
    input  logic [c3f_pkg::POS_W-1:0]    i_up_waddr,
    output logic [c3f_pkg::PIX_W-1:0]    o_up,
    output logic [c3f_pkg::PIX_W-1:0]    o_mid
);

    logic [c3f_pkg::PIX_W-1:0] r_upper  [c3f_pkg::MAX_WIDTH];
    logic [c3f_pkg::PIX_W-1:0] r_middle [c3f_pkg::MAX_WIDTH];
    logic [c3f_pkg::PIX_W-1:0] r_up_q;
    logic [c3f_pkg::PIX_W-1:0] r_mid_q;

    // middle store: read old entry and write the new pixel in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_mid_q              <= r_middle[i_rd_addr];
            r_middle[i_rd_addr]  <= i_mid_wdata;
        end
    end

    // upper store takes the old middle entry in the cycle after it is read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_up_q <= r_upper[i_rd_addr];
        end
        if (i_up_we) begin
            r_upper[i_up_waddr] <= r_mid_q;
        end
    end

    assign o_up  = r_up_q;
    assign o_mid = r_mid_q;

endmodule

// ===== hdl/c3f_out_queue.sv =====
// ----------------------------------------------------------------------------
// c3f_out_queue
// Small request queue and output register that unrolls each request into results.
// ----------------------------------------------------------------------------
module c3f_out_queue (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  c3f_pkg::t_rec                      i_rec,
    output logic [c3f_pkg::QCNT_W-1:0]         o_count,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [c3f_pkg::VAL_W-1:0]   o_value,
    output logic [c3f_pkg::POS_W-1:0]          o_row,
    output logic [c3f_pkg::POS_W-1:0]          o_col,
    output logic                               o_last_of_run,
    output logic                               o_last_of_image
);

    c3f_pkg::t_rec                 r_mem [c3f_pkg::QUEUE_DEPTH];
    logic [c3f_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [c3f_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [c3f_pkg::QCNT_W-1:0]    r_count;
    logic [c3f_pkg::QCNT_W-1:0]    n_count;
    c3f_pkg::t_rec                 r_cur;
    logic [2:0]                    r_mask;
    logic [2:0]                    n_mask;
    c3f_pkg::t_rec                 w_head;
    logic [2:0]                    w_sel;
    logic [2:0]                    w_after;
    logic                          w_fire;
    logic                          w_pop;

    always_comb begin
        w_head  = r_mem[r_rd_ptr];
        w_sel   = r_mask & (~r_mask + 3'd1);
        w_fire  = (r_mask != 3'd0) && !i_stall;
        w_after = w_fire ? (r_mask & ~w_sel) : r_mask;
        w_pop   = (w_after == 3'd0) && (r_count != '0);
        n_count = r_count + c3f_pkg::QCNT_W'(i_push) - c3f_pkg::QCNT_W'(w_pop);
        if (w_pop) begin
            n_mask = {w_head.e_last, w_head.e_end, w_head.e_win};
        end else begin
            n_mask = w_after;
        end
    end

    // result fields
    always_comb begin
        o_valid       = (r_mask != 3'd0);
        o_last_of_run = ((r_mask & ~w_sel) == 3'd0);
        if (w_sel[0]) begin
            o_value         = r_cur.win_val;
            o_row           = r_cur.row - c3f_pkg::POS_W'(1);
            o_col           = r_cur.col - c3f_pkg::POS_W'(1);
            o_last_of_image = 1'b0;
        end else if (w_sel[1]) begin
            o_value         = $signed({{(c3f_pkg::VAL_W - c3f_pkg::PIX_W){1'b0}}, r_cur.end_val});
            o_row           = r_cur.row - c3f_pkg::POS_W'(1);
            o_col           = r_cur.col;
            o_last_of_image = 1'b0;
        end else begin
            o_value         = $signed({{(c3f_pkg::VAL_W - c3f_pkg::PIX_W){1'b0}}, r_cur.last_val});
            o_row           = r_cur.row;
            o_col           = r_cur.col;
            o_last_of_image = r_cur.img_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
        if (w_pop) begin
            r_cur <= w_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_mask   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + c3f_pkg::QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + c3f_pkg::QPTR_W'(1);
            end
            r_count <= n_count;
            r_mask  <= n_mask;
        end
    end

    assign o_count = r_count;

endmodule

// ===== sim/conv3x3_image_filter_top_tb.sv =====
// ----------------------------------------------------------------------------
// conv3x3_image_filter_top_tb
// Self-checking bench for the 3x3 image filter. Pixels go in through the
// valid/stall request channel. A cycle-free model of the line stores, window
// and row/column counters predicts every result, and each result taken from
// the output channel is compared field by field against the oldest prediction.
// The run covers reset geometry, coefficient and size extremes, geometry
// changes in mid-image, the stock kernels, a long output hold-off and random
// small images with random idling on both channels.
// ----------------------------------------------------------------------------
module conv3x3_image_filter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD      = 20;
    localparam int RST_CYCLES      = 10;
    localparam int IDLE_PCT        = 18;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int RANDOM_PIXELS   = 24;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_NS     = 10_000_000;
    localparam int NUM_STOCK       = 5;
    localparam int PRIME_COLS      = 16;

    localparam logic [c3f_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic [c3f_pkg::KERN_W-1:0] KERN_SHARPEN  = 36'h1E1E5E1E1;
    localparam logic [c3f_pkg::KERN_W-1:0] KERN_SOBEL    = 36'h10F20E10F;
    localparam logic [c3f_pkg::KERN_W-1:0] KERN_LAPLACE  = 36'h0101C1010;
    localparam logic [c3f_pkg::KERN_W-1:0] KERN_EDGE     = 36'h00001F000;
    localparam logic [c3f_pkg::KERN_W-1:0] KERN_EMBOSS   = 36'h21011F0FE;
    localparam logic [c3f_pkg::KERN_W-1:0] KERN_ALL_MAX  = 36'h777777777;
    localparam logic [c3f_pkg::KERN_W-1:0] KERN_ALL_MIN  = 36'h888888888;

    typedef struct packed {
        logic signed [c3f_pkg::VAL_W-1:0] value;
        logic [c3f_pkg::POS_W-1:0]        row;
        logic [c3f_pkg::POS_W-1:0]        col;
        logic                             run_end;
        logic                             img_end;
    } t_pixel_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             i_in_valid;
    logic                             o_in_stall;
    logic [c3f_pkg::PIX_W-1:0]        i_pixel;
    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    logic signed [c3f_pkg::VAL_W-1:0] o_value;
    logic [c3f_pkg::POS_W-1:0]        o_out_row;
    logic [c3f_pkg::POS_W-1:0]        o_out_col;
    logic                             o_last_of_run;
    logic                             o_last_of_image;
    logic                             i_cfg_we;
    logic [c3f_pkg::CFG_IDX_W-1:0]    i_cfg_index;
    logic [c3f_pkg::CFG_DATA_W-1:0]   i_cfg_data;

    bit idle_en         = 1'b1;
    int hold_off_left   = 0;
    int fail_count      = 0;
    int pixels_sent     = 0;
    int results_checked = 0;
    int cfg_writes      = 0;
    int images_done     = 0;

    t_pixel_result due_results [$];

    // filter state as seen from outside
    logic [c3f_pkg::KERN_W-1:0] kern_reg   = '0;
    logic [c3f_pkg::DIM_W-1:0]  width_reg  = c3f_pkg::DIM_W'(c3f_pkg::MAX_WIDTH);
    logic [c3f_pkg::DIM_W-1:0]  height_reg = c3f_pkg::DIM_W'(c3f_pkg::MAX_HEIGHT);
    logic [c3f_pkg::PIX_W-1:0]  upper_line [c3f_pkg::MAX_WIDTH] = '{default: '0};
    logic [c3f_pkg::PIX_W-1:0]  middle_line [c3f_pkg::MAX_WIDTH] = '{default: '0};
    logic [c3f_pkg::PIX_W-1:0]  win [3][3] = '{default: '0};
    int                         row_cnt = 0;
    int                         col_cnt = 0;

    conv3x3_image_filter_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_pixel         (i_pixel),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_value         (o_value),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_last_of_run   (o_last_of_run),
        .o_last_of_image (o_last_of_image),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int limit_dim(input logic [c3f_pkg::DIM_W-1:0] v, input int hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    function automatic logic signed [c3f_pkg::VAL_W-1:0] kernel_sum();
        int acc;
        acc = 0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                acc += int'(win[i][j])
                     * int'($signed(kern_reg[c3f_pkg::COEF_W*(i*3+j) +: c3f_pkg::COEF_W]));
            end
        end
        return acc[c3f_pkg::VAL_W-1:0];
    endfunction

    function automatic void convolve_pixel(input logic [c3f_pkg::PIX_W-1:0] pix);
        int                        w, h, r, c, idx, n;
        logic                      row_end, last_row, inner;
        logic [c3f_pkg::PIX_W-1:0] up, mid;
        t_pixel_result             batch [3];
        w        = limit_dim(width_reg, c3f_pkg::MAX_WIDTH);
        h        = limit_dim(height_reg, c3f_pkg::MAX_HEIGHT);
        r        = row_cnt;
        c        = col_cnt;
        idx      = (c < c3f_pkg::MAX_WIDTH) ? c : c3f_pkg::MAX_WIDTH - 1;
        row_end  = (c >= w - 1);
        last_row = (r >= h - 1);
        up       = upper_line[idx];
        mid      = middle_line[idx];
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = up;
        win[1][2] = mid;
        win[2][2] = pix;
        upper_line[idx]  = mid;
        middle_line[idx] = pix;
        n = 0;
        if (r >= 1 && c >= 1) begin
            inner = (r >= 2) && (c >= 2) && (r <= h - 1) && (c <= w - 1);
            batch[n] = '{inner ? kernel_sum() : c3f_pkg::VAL_W'(win[1][1]),
                         c3f_pkg::POS_W'(r - 1), c3f_pkg::POS_W'(c - 1), 1'b0, 1'b0};
            n++;
        end
        if (row_end && r >= 1) begin
            batch[n] = '{c3f_pkg::VAL_W'(win[1][2]), c3f_pkg::POS_W'(r - 1),
                         c3f_pkg::POS_W'(c), 1'b0, 1'b0};
            n++;
        end
        if (last_row) begin
            batch[n] = '{c3f_pkg::VAL_W'(pix), c3f_pkg::POS_W'(r), c3f_pkg::POS_W'(c),
                         1'b0, row_end};
            n++;
        end
        if (n > 0) batch[n-1].run_end = 1'b1;
        for (int k = 0; k < n; k++) begin
            due_results.push_back(batch[k]);
        end
        if (row_end) begin
            col_cnt = 0;
            if (last_row) begin
                row_cnt = 0;
                images_done++;
            end else begin
                row_cnt = r + 1;
            end
        end else begin
            col_cnt = c + 1;
        end
    endfunction

    function automatic logic [c3f_pkg::KERN_W-1:0] stock_kernel(input int sel);
        case (sel)
            0:       return KERN_SHARPEN;
            1:       return KERN_SOBEL;
            2:       return KERN_LAPLACE;
            3:       return KERN_EDGE;
            default: return KERN_EMBOSS;
        endcase
    endfunction

    function automatic logic [c3f_pkg::KERN_W-1:0] rand_kernel();
        return {4'($urandom_range(0, 15)), 32'($urandom)};
    endfunction

    function automatic logic [c3f_pkg::PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return c3f_pkg::PIX_W'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [c3f_pkg::CFG_IDX_W-1:0] idx,
                             input logic [c3f_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        case (idx)
            c3f_pkg::REG_KERNEL: kern_reg = data[c3f_pkg::KERN_W-1:0];
            c3f_pkg::REG_WIDTH:  width_reg = data[c3f_pkg::DIM_W-1:0];
            c3f_pkg::REG_HEIGHT: height_reg = data[c3f_pkg::DIM_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic send_pixel(input logic [c3f_pkg::PIX_W-1:0] pix);
        while (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel    <= pix;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        convolve_pixel(pix);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic feed_pixels(input int count);
        repeat (count) send_pixel(rand_pixel());
    endtask

    task automatic finish_image();
        do begin
            send_pixel(rand_pixel());
        end while (row_cnt != 0 || col_cnt != 0);
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (due_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge i_clk);
            waited++;
        end
        if (due_results.size() != 0) begin
            $error("%0d expected results never arrived", due_results.size());
            fail_count++;
            due_results.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic test_reset_defaults();
        // reset kernel and geometry on a partial first row, then a short ten-wide
        // image; this also fills every line store column that later images reach
        idle_en = 1'b0;
        feed_pixels(PRIME_COLS);
        drain_results();
        write_reg(c3f_pkg::REG_WIDTH, c3f_pkg::CFG_DATA_W'(10));
        write_reg(c3f_pkg::REG_HEIGHT, '0);
        finish_image();
        drain_results();
        idle_en = 1'b1;
    endtask

    task automatic test_kernel_extremes();
        write_reg(c3f_pkg::REG_WIDTH, c3f_pkg::CFG_DATA_W'(3));
        write_reg(c3f_pkg::REG_HEIGHT, c3f_pkg::CFG_DATA_W'(3));
        write_reg(c3f_pkg::REG_KERNEL, KERN_ALL_MAX);
        repeat (9) send_pixel('1);
        drain_results();
        write_reg(c3f_pkg::REG_KERNEL, KERN_ALL_MIN);
        repeat (9) send_pixel('1);
        drain_results();
    endtask

    task automatic test_geometry_extremes();
        write_reg(c3f_pkg::REG_KERNEL, KERN_SHARPEN);
        // widest setting on a partial row, the narrowest then ends it
        write_reg(c3f_pkg::REG_WIDTH, c3f_pkg::CFG_DATA_W'({c3f_pkg::DIM_W{1'b1}}));
        write_reg(c3f_pkg::REG_HEIGHT, c3f_pkg::CFG_DATA_W'(2));
        feed_pixels(6);
        drain_results();
        write_reg(c3f_pkg::REG_WIDTH, '0);
        finish_image();
        drain_results();
        // tallest setting for four rows, the shortest then ends the image
        write_reg(c3f_pkg::REG_HEIGHT, c3f_pkg::CFG_DATA_W'({c3f_pkg::DIM_W{1'b1}}));
        feed_pixels(12);
        drain_results();
        write_reg(c3f_pkg::REG_HEIGHT, c3f_pkg::CFG_DATA_W'(2));
        finish_image();
        drain_results();
    endtask

    task automatic test_midimage_changes();
        write_reg(c3f_pkg::REG_KERNEL, KERN_LAPLACE);
        write_reg(c3f_pkg::REG_WIDTH, c3f_pkg::CFG_DATA_W'(8));
        write_reg(c3f_pkg::REG_HEIGHT, c3f_pkg::CFG_DATA_W'(6));
        feed_pixels(22);
        drain_results();
        // column already past the new last column
        write_reg(c3f_pkg::REG_WIDTH, c3f_pkg::CFG_DATA_W'(4));
        feed_pixels(3);
        drain_results();
        // row grows while under way
        write_reg(c3f_pkg::REG_WIDTH, c3f_pkg::CFG_DATA_W'(10));
        write_reg(c3f_pkg::REG_KERNEL, KERN_EMBOSS);
        feed_pixels(11);
        drain_results();
        // row already past the new last row
        write_reg(c3f_pkg::REG_HEIGHT, c3f_pkg::CFG_DATA_W'(3));
        feed_pixels(7);
        drain_results();
        write_reg(REG_UNUSED, rand_kernel());
        write_reg(c3f_pkg::REG_WIDTH, c3f_pkg::CFG_DATA_W'(3));
        feed_pixels(9);
        drain_results();
    endtask

    task automatic test_stock_kernels();
        write_reg(c3f_pkg::REG_WIDTH, c3f_pkg::CFG_DATA_W'(3));
        write_reg(c3f_pkg::REG_HEIGHT, c3f_pkg::CFG_DATA_W'(3));
        for (int s = 0; s < NUM_STOCK; s++) begin
            write_reg(c3f_pkg::REG_KERNEL, stock_kernel(s));
            feed_pixels(9);
            drain_results();
        end
    endtask

    task automatic test_backpressure();
        write_reg(c3f_pkg::REG_KERNEL, rand_kernel());
        write_reg(c3f_pkg::REG_WIDTH, c3f_pkg::CFG_DATA_W'(6));
        write_reg(c3f_pkg::REG_HEIGHT, c3f_pkg::CFG_DATA_W'(4));
        hold_off_left = HOLD_OFF_CYCLES;
        feed_pixels(24);
        drain_results();
    endtask

    task automatic test_random_images();
        int start;
        int sel;
        start = pixels_sent;
        while (pixels_sent - start < RANDOM_PIXELS) begin
            sel = $urandom_range(0, 5);
            if (sel < 2) begin
                write_reg(c3f_pkg::REG_KERNEL,
                          stock_kernel($urandom_range(0, NUM_STOCK - 1)));
            end else if (sel < 4) begin
                write_reg(c3f_pkg::REG_KERNEL, rand_kernel());
            end else if (sel == 4) begin
                write_reg(c3f_pkg::REG_KERNEL,
                          $urandom_range(0, 1) ? KERN_ALL_MAX : KERN_ALL_MIN);
            end
            write_reg(c3f_pkg::REG_WIDTH, c3f_pkg::CFG_DATA_W'($urandom_range(0, 9)));
            write_reg(c3f_pkg::REG_HEIGHT, c3f_pkg::CFG_DATA_W'($urandom_range(0, 6)));
            if ($urandom_range(0, 5) == 0) begin
                // broken-off image, the next geometry takes over the counts
                feed_pixels($urandom_range(1, 12));
            end else begin
                finish_image();
            end
            drain_results();
        end
    endtask

    initial begin : result_stall
        forever begin
            @(negedge i_clk);
            if (hold_off_left > 0) begin
                i_out_stall <= 1'b1;
                hold_off_left--;
            end else begin
                i_out_stall <= idle_en && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_pixel_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_results.size() == 0) begin
                $error("unexpected result at row %0d col %0d", o_out_row, o_out_col);
                fail_count++;
            end else begin
                want = due_results.pop_front();
                results_checked++;
                if (o_value !== want.value) begin
                    $error("value: expected %0d, got %0d", want.value, o_value);
                    fail_count++;
                end
                if (o_out_row !== want.row) begin
                    $error("out_row: expected %0d, got %0d", want.row, o_out_row);
                    fail_count++;
                end
                if (o_out_col !== want.col) begin
                    $error("out_col: expected %0d, got %0d", want.col, o_out_col);
                    fail_count++;
                end
                if (o_last_of_run !== want.run_end) begin
                    $error("last_of_run: expected %0b, got %0b", want.run_end, o_last_of_run);
                    fail_count++;
                end
                if (o_last_of_image !== want.img_end) begin
                    $error("last_of_image: expected %0b, got %0b",
                           want.img_end, o_last_of_image);
                    fail_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("run timed out with %0d results outstanding", due_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_pixel     = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = c3f_pkg::REG_KERNEL;
        i_cfg_data  = '0;
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_defaults();
        test_kernel_extremes();
        test_geometry_extremes();
        test_midimage_changes();
        test_stock_kernels();
        test_backpressure();
        test_random_images();
        drain_results();
        $display("covered %0d pixels over %0d finished images and %0d register writes",
                 pixels_sent, images_done, cfg_writes);
        $display("checked %0d results, %0d mismatches", results_checked, fail_count);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/c3f_pkg.sv
hdl/c3f_tap_cell.sv
hdl/c3f_line_buf.sv
hdl/c3f_out_queue.sv
hdl/conv3x3_image_filter_top.sv
sim/conv3x3_image_filter_top_tb.sv
